// ===== hdl/spsu_pkg.sv =====
// Shared constants, register map and result type of the sensor period statistics unit.
package spsu_pkg;

  localparam int unsigned MaxSamplesDef = 1023;
  localparam int unsigned AdcBitsDef    = 12;

  localparam int unsigned TempW     = 16;
  localparam int unsigned CodeFldW  = 12;
  localparam int unsigned CountOutW = 10;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned PAddrW = 3;
  localparam logic [15:0] SlopeRst  = 16'd4096;
  localparam logic [15:0] OffsetRst = 16'd0;

  typedef enum logic {
    RegSlope  = 1'b0,
    RegOffset = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ModeSample = 1'b0,
    ModeClose  = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [TempW-1:0] min_temp;
    logic signed [TempW-1:0] max_temp;
    logic signed [TempW-1:0] avg_temp;
    logic [CountOutW-1:0]    sample_count;
    logic                    empty_res;
    logic                    overflow;
  } res_t;

endpackage

// ===== hdl/spsu_front.sv =====
// Front part: scales converter codes and keeps the running period statistics.
module spsu_front import spsu_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned ADC_BITS    = AdcBitsDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = TempW + CntW,
  localparam int unsigned EntW = 2 * TempW + SumW + CntW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                mode_i,
  input  logic [CodeFldW-1:0] sample_code_i,
  input  logic [15:0]         slope_i,
  input  logic [15:0]         offset_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [EntW-1:0]     q_data_o
);

  localparam int unsigned CodeW = (ADC_BITS < CodeFldW) ? ADC_BITS : CodeFldW;
  localparam int unsigned ProdW = 16 + CodeW;
  localparam int unsigned ShW   = ProdW - 8;
  localparam int unsigned DW    = ShW + 2;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_mode_q;
  logic [ShW-1:0]   s1_prod_q;
  logic [ProdW-1:0] prod;
  logic             s1_go, accept;

  logic signed [TempW-1:0] min_q, min_d, max_q, max_d, temp;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    drop_q, drop_d;
  logic signed [DW-1:0]    diff;
  logic                    pos_ovf, neg_ovf;

  assign prod   = ProdW'(slope_i) * ProdW'(sample_code_i[CodeW-1:0]);
  assign s1_go  = s1_valid_q && !(s1_mode_q == ModeClose && q_full_i);
  assign full_o = s1_valid_q && !s1_go;
  assign accept = push_i && !full_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= mode_i;
      s1_prod_q <= prod[ProdW-1:8];
    end
  end

  assign diff    = $signed({2'b00, s1_prod_q}) - $signed({{(DW-16){offset_i[15]}}, offset_i});
  assign pos_ovf = !diff[DW-1] && (|diff[DW-2:15]);
  assign neg_ovf = diff[DW-1] && !(&diff[DW-2:15]);

  always_comb begin
    if (pos_ovf) begin
      temp = 16'sh7fff;
    end else if (neg_ovf) begin
      temp = 16'sh8000;
    end else begin
      temp = diff[15:0];
    end
  end

  always_comb begin
    min_d    = min_q;
    max_d    = max_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    q_push_o = 1'b0;
    if (s1_go) begin
      if (s1_mode_q == ModeClose) begin
        q_push_o = 1'b1;
        min_d    = '0;
        max_d    = '0;
        sum_d    = '0;
        cnt_d    = '0;
        drop_d   = 1'b0;
      end else if (cnt_q == CntW'(MAX_SAMPLES)) begin
        drop_d = 1'b1;
      end else begin
        if (cnt_q == '0 || temp < min_q) min_d = temp;
        if (cnt_q == '0 || temp > max_q) max_d = temp;
        sum_d = sum_q + $signed({{(SumW-TempW){temp[TempW-1]}}, temp});
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

  assign q_data_o = {drop_q, cnt_q, sum_q, max_q, min_q};

endmodule

// ===== hdl/spsu_fifo.sv =====
// Short register queue carrying closed-period snapshots to the back part.
module spsu_fifo import spsu_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [LW-1:0]    lvl_q;
  logic             do_push, do_pop;

  assign full_o  = lvl_q == LW'(DEPTH);
  assign empty_o = lvl_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      lvl_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        lvl_q <= lvl_q + LW'(1);
      end else if (do_pop && !do_push) begin
        lvl_q <= lvl_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/spsu_back.sv =====
// Back part: serial average divider and the result register.
module spsu_back import spsu_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = TempW + CntW,
  localparam int unsigned EntW = 2 * TempW + SumW + CntW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  logic [EntW-1:0] q_data_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output res_t            res_o
);

  localparam int unsigned StW = $clog2(SumW + 1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e state_q;

  logic signed [TempW-1:0] e_min, e_max;
  logic signed [SumW-1:0]  e_sum;
  logic [CntW-1:0]         e_cnt;
  logic                    e_drop;

  logic signed [TempW-1:0] min_q, max_q;
  logic [CntW-1:0]         cnt_q, rem_q;
  logic                    drop_q, neg_q;
  logic [SumW-1:0]         dvd_q;
  logic [StW-1:0]          step_q;
  logic                    out_valid_q;
  res_t                    out_q;

  logic [CntW:0]   shifted, trial;
  logic            ge;
  logic [SumW-1:0] quot;
  logic            load_out;

  assign {e_drop, e_cnt, e_sum, e_max, e_min} = q_data_i;

  assign q_pop_o  = state_q == StIdle && !q_empty_i;
  assign load_out = state_q == StDone && (!out_valid_q || pop_i);

  assign shifted = {rem_q, dvd_q[SumW-1]};
  assign ge      = shifted >= {1'b0, cnt_q};
  assign trial   = shifted - {1'b0, cnt_q};
  assign quot    = neg_q ? (~dvd_q + SumW'(1)) : dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (!q_empty_i) begin
            min_q   <= e_min;
            max_q   <= e_max;
            cnt_q   <= e_cnt;
            drop_q  <= e_drop;
            neg_q   <= e_sum[SumW-1];
            dvd_q   <= e_sum[SumW-1] ? (~e_sum + SumW'(1)) : e_sum;
            rem_q   <= '0;
            step_q  <= StW'(SumW);
            state_q <= StDiv;
          end
        end
        StDiv: begin
          rem_q  <= ge ? trial[CntW-1:0] : shifted[CntW-1:0];
          dvd_q  <= {dvd_q[SumW-2:0], ge};
          step_q <= step_q - StW'(1);
          if (step_q == StW'(1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
            if (cnt_q == '0) begin
              out_q.min_temp     <= '0;
              out_q.max_temp     <= '0;
              out_q.avg_temp     <= '0;
              out_q.sample_count <= '0;
              out_q.empty_res    <= 1'b1;
            end else begin
              out_q.min_temp     <= min_q;
              out_q.max_temp     <= max_q;
              out_q.avg_temp     <= quot[TempW-1:0];
              out_q.sample_count <= CountOutW'(cnt_q);
              out_q.empty_res    <= 1'b0;
            end
            out_q.overflow <= drop_q;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

endmodule

// ===== hdl/sensor_period_stats_unit.sv =====
// Top level of the sensor period statistics unit: config registers, front, queue and back.
// Sample transfers: one per cycle, held while a close waits on a full snapshot queue;
//   each passes a multiply stage and an update stage. Close transfers go to the snapshot
//   queue, then through the bit-serial divider in the back part before the result is offered.
// Back-to-back closes wait in the queue; the divider takes the next snapshot only when idle.
// Reset clears all period state and the queue; slope returns to 4096 and offset to 0.
module sensor_period_stats_unit import spsu_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned ADC_BITS    = AdcBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode_i,
  input  logic [CodeFldW-1:0]         sample_code_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [TempW-1:0]     min_temp_o,
  output logic signed [TempW-1:0]     max_temp_o,
  output logic signed [TempW-1:0]     avg_temp_o,
  output logic [CountOutW-1:0]        sample_count_o,
  output logic                        empty_res_o,
  output logic                        overflow_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PAddrW-1:0]           paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = TempW + CntW;
  localparam int unsigned EntW = 2 * TempW + SumW + CntW + 1;

  logic [15:0]     slope_q, offset_q;
  logic            cfg_wr;
  logic            q_push, q_full, q_pop, q_empty;
  logic [EntW-1:0] q_wdata, q_rdata;
  res_t            res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q  <= SlopeRst;
      offset_q <= OffsetRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        RegSlope:  slope_q  <= pwdata[15:0];
        RegOffset: offset_q <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      RegSlope:  prdata = {16'd0, slope_q};
      RegOffset: prdata = {{16{offset_q[15]}}, offset_q};
      default:   prdata = '0;
    endcase
  end

  spsu_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .ADC_BITS   (ADC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .mode_i       (mode_i),
    .sample_code_i(sample_code_i),
    .slope_i      (slope_q),
    .offset_i     (offset_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  spsu_fifo #(
    .WIDTH(EntW),
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  spsu_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .res_o    (res)
  );

  assign min_temp_o     = res.min_temp;
  assign max_temp_o     = res.max_temp;
  assign avg_temp_o     = res.avg_temp;
  assign sample_count_o = res.sample_count;
  assign empty_res_o    = res.empty_res;
  assign overflow_o     = res.overflow;

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("snapshot pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("snapshot popped from an empty queue");

  a_empty_period_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_res_o) |-> (sample_count_o == '0 && min_temp_o == '0
                                 && max_temp_o == '0 && avg_temp_o == '0))
    else $error("empty period result carries nonzero statistics");

endmodule
